// ----- design/mcrp_pkg.sv -----
package mcrp_pkg;

   typedef enum logic [1:0] {
      PH_HASH   = 2'd0,
      PH_HEADER = 2'd1,
      PH_RECORD = 2'd2
   } phase_type;

   localparam int HASH_W   = 64;
   localparam int MOVE_W   = 16;
   localparam int COUNT_W  = 20;
   localparam int REMAIN_W = 15;
   localparam int HEADER_W = 16;
   localparam int RECORD_W = 32;

   // Bytes in one record for each header mode, and bytes in one header
   localparam logic [2:0] FLAT_RECORD_BYTES    = 3'd2;
   localparam logic [2:0] COUNTED_RECORD_BYTES = 3'd4;
   localparam logic [2:0] HEADER_BYTES         = 3'd2;

   typedef struct packed {
      logic [HASH_W-1:0]  position_hash;
      logic [MOVE_W-1:0]  move_id;
      logic [COUNT_W-1:0] move_count;
      logic               flat_record;
      logic               last_of_position;
      logic               empty_position;
      logic               truncated;
   } result_type;

   typedef struct packed {
      logic room;
      logic valid;
   } queue_status_type;

endpackage

// ----- design/mcrp_parser.sv -----
module mcrp_parser
   import mcrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       end_of_stream,
   output logic       emit,
   output result_type result
);

   phase_type             phase_ff, phase_in;
   logic [2:0]            bpos_ff, bpos_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [HEADER_W-1:0]   header_ff, header_in;
   logic [RECORD_W-1:0]   record_ff, record_in;
   logic [REMAIN_W-1:0]   remain_ff, remain_in;
   logic                  flat_ff, flat_in;

   always_comb begin
      logic [2:0] bpos_inc;
      logic [2:0] need;
      logic       mid;

      bpos_inc  = bpos_ff + 3'd1;
      need      = flat_ff ? FLAT_RECORD_BYTES : COUNTED_RECORD_BYTES;
      phase_in  = phase_ff;
      bpos_in   = bpos_inc;
      hash_in   = hash_ff;
      header_in = header_ff;
      record_in = record_ff;
      remain_in = remain_ff;
      flat_in   = flat_ff;
      emit      = 1'b0;
      result    = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            header_in = {header_ff[7:0], data_byte};
            if (bpos_inc >= HEADER_BYTES) begin
               bpos_in   = 3'd0;
               flat_in   = header_in[HEADER_W-1];
               remain_in = header_in[REMAIN_W-1:0];
               if (remain_in == '0) begin
                  emit                    = 1'b1;
                  result.position_hash    = hash_ff;
                  result.flat_record      = flat_in;
                  result.last_of_position = 1'b1;
                  result.empty_position   = 1'b1;
                  phase_in                = PH_HASH;
               end else begin
                  phase_in = PH_RECORD;
               end
            end
         end
         PH_RECORD: begin
            record_in = {record_ff[RECORD_W-9:0], data_byte};
            if (bpos_inc >= need) begin
               bpos_in              = 3'd0;
               emit                 = 1'b1;
               result.position_hash = hash_ff;
               result.flat_record   = flat_ff;
               if (flat_ff) begin
                  result.move_id    = record_in[MOVE_W-1:0];
                  result.move_count = COUNT_W'(1);
               end else begin
                  result.move_id    = {4'd0, record_in[RECORD_W-1:COUNT_W]};
                  result.move_count = record_in[COUNT_W-1:0];
               end
               remain_in = remain_ff - REMAIN_W'(1);
               if (remain_in == '0) begin
                  result.last_of_position = 1'b1;
                  phase_in                = PH_HASH;
               end
            end
         end
         default: begin
            // unused phase code behaves as hash phase
            phase_in = PH_HASH;
            hash_in  = {hash_ff[HASH_W-9:0], data_byte};
            if (bpos_inc == 3'd0) begin
               phase_in  = PH_HEADER;
               header_in = '0;
            end
         end
      endcase

      if (end_of_stream) begin
         mid = !(phase_in == PH_HASH && bpos_in == 3'd0);
         if (mid) begin
            if (!emit) begin
               result = '0;
            end
            emit             = 1'b1;
            result.truncated = 1'b1;
         end
         // return to reset state for the next stream
         phase_in  = PH_HASH;
         bpos_in   = 3'd0;
         hash_in   = '0;
         header_in = '0;
         record_in = '0;
         remain_in = '0;
         flat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HASH;
         bpos_ff   <= 3'd0;
         hash_ff   <= '0;
         header_ff <= '0;
         record_ff <= '0;
         remain_ff <= '0;
         flat_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         bpos_ff   <= bpos_in;
         hash_ff   <= hash_in;
         header_ff <= header_in;
         record_ff <= record_in;
         remain_ff <= remain_in;
         flat_ff   <= flat_in;
      end
   end

endmodule

// ----- design/mcrp_result_queue.sv -----
module mcrp_result_queue
   import mcrp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  result_type       push_data,
   input  logic             pop,
   output queue_status_type status,
   output result_type       head
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign status.room  = (count_ff != 2'd2);
   assign status.valid = (count_ff != 2'd0);
   assign head         = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/move_count_record_parser_unit.sv -----
// Move-count record parser: takes a big-endian byte stream of position
// entries (8-byte hash, 2-byte header, records) on the req_ channel, one
// byte per transfer, with req_end_of_stream on the final byte.
// The rsp_ channel gives one result per completed record, a marker result
// for a position with no records, and a truncation result when the stream
// ends inside an entry.
// Throughput: one byte per cycle while the result queue has room. Each byte is
// held in the input register and takes one pass through the parser step logic,
// which updates the parse state and writes the result queue.
// A result is visible on rsp_ once the byte that completes it has passed the
// input register and the parser step, and transfers when rsp_stall is low.
// A two-entry result queue keeps bytes flowing while one result waits on
// a stalled receiver; req_stall rises only when the input register holds a
// byte and the queue is full. Bytes that produce no result wait as well
// until the queue has room.
// Reset (synchronous) empties the queue and input register and returns the
// parser to the start of a hash. After the end-of-stream byte the parser
// is ready for a new stream.
module move_count_record_parser_unit
   import mcrp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_stream,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [HASH_W-1:0]  rsp_position_hash,
   output logic [MOVE_W-1:0]  rsp_move_id,
   output logic [COUNT_W-1:0] rsp_move_count,
   output logic               rsp_flat_record,
   output logic               rsp_last_of_position,
   output logic               rsp_empty_position,
   output logic               rsp_truncated
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_eos_ff;
   logic             req_xfer;
   logic             consume;
   logic             emit;
   logic             pop;
   result_type       step_result;
   result_type       head;
   queue_status_type qstat;

   assign consume   = in_valid_ff && qstat.room;
   assign req_stall = in_valid_ff && !qstat.room;
   assign req_xfer  = req_valid && !req_stall;
   assign pop       = qstat.valid && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   mcrp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (consume),
      .data_byte     (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .emit          (emit),
      .result        (step_result)
   );

   mcrp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (consume && emit),
      .push_data (step_result),
      .pop       (pop),
      .status    (qstat),
      .head      (head)
   );

   assign rsp_valid            = qstat.valid;
   assign rsp_position_hash    = head.position_hash;
   assign rsp_move_id          = head.move_id;
   assign rsp_move_count       = head.move_count;
   assign rsp_flat_record      = head.flat_record;
   assign rsp_last_of_position = head.last_of_position;
   assign rsp_empty_position   = head.empty_position;
   assign rsp_truncated        = head.truncated;

   a_full_has_result : assert property (@(posedge clock) disable iff (reset)
      !qstat.room |-> rsp_valid)
      else $error("result queue full without a result on rsp");

   a_consume_drains : assert property (@(posedge clock) disable iff (reset)
      (consume && !req_xfer) |=> !in_valid_ff)
      else $error("input register kept a byte that was consumed");

   a_trunc_not_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truncated) |-> !rsp_empty_position)
      else $error("truncation flagged on an empty-position marker");

   a_empty_marker : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_position) |->
         (rsp_last_of_position && rsp_move_count == '0 && rsp_move_id == '0))
      else $error("empty-position marker carries a record");

endmodule

// ----- test/tb_move_count_record_parser_unit.sv -----
`timescale 1ns / 100ps

module tb_move_count_record_parser_unit;
   import mcrp_pkg::*;

   localparam int TOTAL_BYTES = 1250;
   localparam int QUIET_FROM  = 1100;
   localparam int HOLD_CYCLES = 150;
   localparam int HOLD_AFTER  = 300;
   localparam int MAX_CUT     = 120;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_data_byte;
   logic               req_end_of_stream;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [HASH_W-1:0]  rsp_position_hash;
   logic [MOVE_W-1:0]  rsp_move_id;
   logic [COUNT_W-1:0] rsp_move_count;
   logic               rsp_flat_record;
   logic               rsp_last_of_position;
   logic               rsp_empty_position;
   logic               rsp_truncated;

   move_count_record_parser_unit DUT (.*);

   always #6 clock = ~clock;

   // Tracks the parse state of the byte stream and holds the records still due.
   class record_tracker;
      phase_type           phase;
      logic [2:0]          byte_pos;
      logic [HASH_W-1:0]   hash_acc;
      logic [HEADER_W-1:0] header_acc;
      logic [RECORD_W-1:0] record_acc;
      logic [REMAIN_W-1:0] remaining;
      logic                flat;
      result_type          expected_records[$];
      int                  failures;

      function new();
         clear();
         failures = 0;
      endfunction

      function void clear();
         phase      = PH_HASH;
         byte_pos   = '0;
         hash_acc   = '0;
         header_acc = '0;
         record_acc = '0;
         remaining  = '0;
         flat       = 1'b0;
      endfunction

      function int pending();
         return expected_records.size();
      endfunction

      function void note_byte(logic [7:0] value, logic last);
         result_type res;
         logic       emit;
         logic [2:0] need;
         res  = '0;
         emit = 1'b0;
         case (phase)
            PH_HEADER: begin
               header_acc = {header_acc[7:0], value};
               byte_pos   = byte_pos + 3'd1;
               if (byte_pos >= HEADER_BYTES) begin
                  byte_pos  = '0;
                  flat      = header_acc[15];
                  remaining = header_acc[14:0];
                  if (remaining == '0) begin
                     emit                 = 1'b1;
                     res.position_hash    = hash_acc;
                     res.flat_record      = flat;
                     res.last_of_position = 1'b1;
                     res.empty_position   = 1'b1;
                     phase                = PH_HASH;
                  end else begin
                     phase = PH_RECORD;
                  end
               end
            end
            PH_RECORD: begin
               need       = flat ? FLAT_RECORD_BYTES : COUNTED_RECORD_BYTES;
               record_acc = {record_acc[23:0], value};
               byte_pos   = byte_pos + 3'd1;
               if (byte_pos >= need) begin
                  byte_pos          = '0;
                  emit              = 1'b1;
                  res.position_hash = hash_acc;
                  res.flat_record   = flat;
                  if (flat) begin
                     res.move_id    = record_acc[15:0];
                     res.move_count = 20'd1;
                  end else begin
                     res.move_id    = {4'd0, record_acc[31:20]};
                     res.move_count = record_acc[19:0];
                  end
                  remaining = remaining - REMAIN_W'(1);
                  if (remaining == '0) begin
                     res.last_of_position = 1'b1;
                     phase                = PH_HASH;
                  end
               end
            end
            default: begin
               // the unused phase code falls back to the hash phase
               phase    = PH_HASH;
               hash_acc = {hash_acc[HASH_W-9:0], value};
               byte_pos = byte_pos + 3'd1;
               if (byte_pos == '0) begin
                  phase      = PH_HEADER;
                  header_acc = '0;
               end
            end
         endcase
         if (last) begin
            if (!(phase == PH_HASH && byte_pos == '0)) begin
               if (!emit) begin
                  emit = 1'b1;
                  res  = '0;
               end
               res.truncated = 1'b1;
            end
            clear();
         end
         if (emit)
            expected_records.push_back(res);
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
            failures++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_records.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual hash %0h move %0h count %0h",
                     $time, got.position_hash, got.move_id, got.move_count);
            failures++;
            return;
         end
         want = expected_records.pop_front();
         compare("position_hash", want.position_hash, got.position_hash);
         compare("move_id", want.move_id, got.move_id);
         compare("move_count", want.move_count, got.move_count);
         compare("flat_record", want.flat_record, got.flat_record);
         compare("last_of_position", want.last_of_position, got.last_of_position);
         compare("empty_position", want.empty_position, got.empty_position);
         compare("truncated", want.truncated, got.truncated);
      endfunction
   endclass

   record_tracker board = new();

   logic [7:0] stream_bytes[$];
   logic       stream_ends[$];
   int         bytes_sent = 0;
   logic       quiet_tail = 1'b0;
   logic       hold_rsp = 1'b0;

   function automatic void push_byte(logic [7:0] value, logic last);
      stream_bytes.push_back(value);
      stream_ends.push_back(last);
   endfunction

   function automatic void build_entry(ref logic [7:0] bytes[$]);
      logic [63:0]         hash;
      logic [REMAIN_W-1:0] count;
      logic                flat_bit;
      logic [31:0]         word;
      int                  width;
      case ($urandom_range(0, 9))
         0:       hash = '0;
         1:       hash = '1;
         default: hash = {$urandom, $urandom};
      endcase
      flat_bit = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
         0:       count = REMAIN_W'($urandom);
         1:       count = '1;
         2, 3:    count = '0;
         default: count = REMAIN_W'($urandom_range(1, 5));
      endcase
      for (int i = 7; i >= 0; i--)
         bytes.push_back(hash[i*8 +: 8]);
      bytes.push_back({flat_bit, count[14:8]});
      bytes.push_back(count[7:0]);
      width = flat_bit ? 2 : 4;
      // long entries get cut by the caller, so stop adding records early
      for (int r = 0; r < count && r < 40; r++) begin
         case ($urandom_range(0, 7))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom;
         endcase
         for (int k = width - 1; k >= 0; k--)
            bytes.push_back(word[k*8 +: 8]);
      end
   endfunction

   function automatic void queue_stream();
      logic [7:0] bytes[$];
      int         cut;
      logic       mark_end;
      for (int e = $urandom_range(1, 4); e > 0; e--)
         build_entry(bytes);
      cut      = bytes.size();
      mark_end = 1'b1;
      if (cut > MAX_CUT || $urandom_range(0, 3) == 0)
         cut = $urandom_range(1, (cut > MAX_CUT) ? MAX_CUT : cut);
      else if ($urandom_range(0, 9) == 0)
         mark_end = 1'b0;
      for (int i = 0; i < cut; i++)
         push_byte(bytes[i], mark_end && i == cut - 1);
   endfunction

   function automatic void queue_noise();
      int len;
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++)
         push_byte(8'($urandom), i == len - 1);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_end_of_stream <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(value, last);
      bytes_sent++;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_end_of_stream <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty flat position, then a counted entry cut after its first record,
      // then a stream that ends inside a hash
      for (int i = 0; i < 8; i++) push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h00, 1'b0);
      for (int i = 0; i < 8; i++) push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h02, 1'b0);
      for (int i = 0; i < 4; i++) push_byte(8'hFF, i == 3);
      push_byte(8'h12, 1'b1);

      while (bytes_sent < TOTAL_BYTES || stream_bytes.size() != 0) begin
         if (stream_bytes.size() == 0) begin
            if ($urandom_range(0, 6) == 0)
               queue_noise();
            else
               queue_stream();
         end
         if (bytes_sent >= QUIET_FROM)
            quiet_tail <= 1'b1;
         send_byte(stream_bytes.pop_front(), stream_ends.pop_front());
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Receiver: check each transfer, stall in random bursts.
   initial begin
      int         stall_left;
      result_type got;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_position_hash, rsp_move_id, rsp_move_count, rsp_flat_record,
                   rsp_last_of_position, rsp_empty_position, rsp_truncated};
            board.check_result(got);
         end
         if (stall_left > 0)
            stall_left--;
         else if (!quiet_tail && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
         rsp_stall <= hold_rsp || stall_left > 0;
      end
   end

   // Hold the result channel long enough for the block to back up its input.
   initial begin
      wait (bytes_sent >= HOLD_AFTER);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/mcrp_pkg.sv
design/mcrp_parser.sv
design/mcrp_result_queue.sv
design/move_count_record_parser_unit.sv
test/tb_move_count_record_parser_unit.sv
